// ----- sv/fprx_pkg.sv -----
`default_nettype none

package fprx_pkg;

  localparam int HEADER_BYTES      = 10;
  localparam int TRAILER_BYTES     = 4;
  localparam int MAX_KEY_BYTES_DEF = 8;

  localparam logic [7:0]  STX_BYTE      = 8'h02;
  localparam logic [31:0] MIN_FRAME_LEN = 32'(HEADER_BYTES + TRAILER_BYTES);
  localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;

  // header byte positions
  localparam logic [3:0] POS_LEN_FIRST = 4'd1;
  localparam logic [3:0] POS_LEN_LAST  = 4'd4;
  localparam logic [3:0] POS_VERSION   = 4'd5;
  localparam logic [3:0] POS_TYPE_HI   = 4'd6;
  localparam logic [3:0] POS_TYPE_LO   = 4'd7;
  localparam logic [3:0] POS_REQ_ID    = 4'd8;

  // configuration register indexes
  localparam int          CFG_IDX_W       = 3;
  localparam logic [2:0]  CFG_XOR_KEY     = 3'd0;
  localparam logic [2:0]  CFG_KEY_LENGTH  = 3'd1;
  localparam logic [2:0]  CFG_MAX_FRAME   = 3'd2;
  localparam logic [2:0]  CFG_MIN_VERSION = 3'd3;
  localparam logic [2:0]  CFG_MAX_VERSION = 3'd4;

  localparam logic [63:0] RST_XOR_KEY     = 64'd0;
  localparam logic [3:0]  RST_KEY_LENGTH  = 4'd8;
  localparam logic [31:0] RST_MAX_FRAME   = 32'd131072;
  localparam logic [7:0]  RST_MIN_VERSION = 8'd10;
  localparam logic [7:0]  RST_MAX_VERSION = 8'd255;

  typedef enum logic [2:0] {
    ST_BUSY     = 3'd0,
    ST_GOOD     = 3'd1,
    ST_NO_STX   = 3'd2,
    ST_BAD_LEN  = 3'd3,
    ST_VER_LOW  = 3'd4,
    ST_VER_HIGH = 3'd5,
    ST_CRC_BAD  = 3'd6,
    ST_DISCARD  = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'b001,
    PH_FRAME = 3'b010,
    PH_ERROR = 3'b100
  } phase_t;

  typedef struct packed {
    logic [63:0] xor_key;
    logic [3:0]  key_length;
    logic [31:0] max_frame;
    logic [7:0]  min_version;
    logic [7:0]  max_version;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  plain_byte;
    logic        payload_flag;
    logic        frame_end;
    status_t     status;
    logic [7:0]  protocol_version;
    logic [15:0] message_type;
    logic [7:0]  request_id;
    logic [7:0]  request_version;
    logic [31:0] frame_length;
  } result_t;

  // reflected crc-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- sv/fprx_parser.sv -----
`default_nettype none

module fprx_parser #(
  parameter int MAX_KEY_BYTES = fprx_pkg::MAX_KEY_BYTES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire logic [7:0]       rx_byte,
  input  wire fprx_pkg::cfg_t   cfg,
  output fprx_pkg::result_t     res
);

  localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

  fprx_pkg::phase_t phase_r, phase_nxt;
  logic [31:0]       pos_r, pos_nxt;
  logic [31:0]       len_r, len_nxt;
  logic [7:0]        ver_r, ver_nxt;
  logic [15:0]       type_r, type_nxt;
  logic [7:0]        id_r, id_nxt;
  logic [7:0]        reqver_r, reqver_nxt;
  logic [31:0]       crc_r, crc_nxt;
  logic [31:0]       trailer_r, trailer_nxt;
  logic [KIDX_W-1:0] kidx_r, kidx_nxt;

  logic [3:0]        hpos;
  logic [7:0]        key_b;
  logic [7:0]        plain;
  logic [4:0]        kidx_inc;
  logic              payload;
  logic              fend;
  fprx_pkg::status_t status;

  assign hpos     = pos_r[3:0];
  assign key_b    = cfg.xor_key[{kidx_r, 3'b000} +: 8];
  assign kidx_inc = 5'(kidx_r) + 5'd1;

  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    len_nxt     = len_r;
    ver_nxt     = ver_r;
    type_nxt    = type_r;
    id_nxt      = id_r;
    reqver_nxt  = reqver_r;
    crc_nxt     = crc_r;
    trailer_nxt = trailer_r;
    kidx_nxt    = kidx_r;
    plain       = rx_byte;
    payload     = 1'b0;
    fend        = 1'b0;
    status      = fprx_pkg::ST_BUSY;
    case (phase_r)
      fprx_pkg::PH_HUNT: begin
        pos_nxt     = '0;
        len_nxt     = '0;
        ver_nxt     = '0;
        type_nxt    = '0;
        id_nxt      = '0;
        reqver_nxt  = '0;
        crc_nxt     = fprx_pkg::CRC_INIT;
        trailer_nxt = '0;
        kidx_nxt    = '0;
        if (rx_byte != fprx_pkg::STX_BYTE) begin
          phase_nxt = fprx_pkg::PH_ERROR;
          fend      = 1'b1;
          status    = fprx_pkg::ST_NO_STX;
        end else begin
          crc_nxt   = fprx_pkg::crc_byte(fprx_pkg::CRC_INIT, rx_byte);
          pos_nxt   = 32'd1;
          phase_nxt = fprx_pkg::PH_FRAME;
        end
      end
      fprx_pkg::PH_FRAME: begin
        pos_nxt = pos_r + 32'd1;
        if (pos_r < 32'(fprx_pkg::HEADER_BYTES)) begin
          crc_nxt = fprx_pkg::crc_byte(crc_r, rx_byte);
          if (hpos >= fprx_pkg::POS_LEN_FIRST && hpos <= fprx_pkg::POS_LEN_LAST) begin
            len_nxt = {len_r[23:0], rx_byte};
          end else if (hpos == fprx_pkg::POS_VERSION) begin
            ver_nxt = rx_byte;
          end else if (hpos == fprx_pkg::POS_TYPE_HI || hpos == fprx_pkg::POS_TYPE_LO) begin
            type_nxt = {type_r[7:0], rx_byte};
          end else if (hpos == fprx_pkg::POS_REQ_ID) begin
            id_nxt = rx_byte;
          end else begin
            reqver_nxt = rx_byte;
          end
          if (hpos == fprx_pkg::POS_LEN_LAST &&
              (len_nxt < fprx_pkg::MIN_FRAME_LEN || len_nxt > cfg.max_frame)) begin
            phase_nxt = fprx_pkg::PH_ERROR;
            fend      = 1'b1;
            status    = fprx_pkg::ST_BAD_LEN;
          end
        end else begin
          plain = rx_byte ^ key_b;
          if (kidx_inc >= {1'b0, cfg.key_length} || kidx_inc >= 5'(MAX_KEY_BYTES)) begin
            kidx_nxt = '0;
          end else begin
            kidx_nxt = kidx_inc[KIDX_W-1:0];
          end
          // length is at least 14 here, so the subtractions cannot wrap
          if (pos_r < len_r - 32'(fprx_pkg::TRAILER_BYTES)) begin
            crc_nxt = fprx_pkg::crc_byte(crc_r, plain);
            payload = 1'b1;
          end else begin
            trailer_nxt = {trailer_r[23:0], plain};
          end
          if (pos_r == len_r - 32'd1) begin
            fend = 1'b1;
            if (ver_r < cfg.min_version) begin
              status = fprx_pkg::ST_VER_LOW;
            end else if (ver_r > cfg.max_version) begin
              status = fprx_pkg::ST_VER_HIGH;
            end else if ((crc_nxt ^ fprx_pkg::CRC_INIT) != trailer_nxt) begin
              status = fprx_pkg::ST_CRC_BAD;
            end else begin
              status = fprx_pkg::ST_GOOD;
            end
            if (status == fprx_pkg::ST_GOOD) begin
              phase_nxt = fprx_pkg::PH_HUNT;
              pos_nxt   = '0;
            end else begin
              phase_nxt = fprx_pkg::PH_ERROR;
            end
          end
        end
      end
      default: begin
        // error phase and unused codes discard until reset
        status = fprx_pkg::ST_DISCARD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= fprx_pkg::PH_HUNT;
      pos_r     <= '0;
      len_r     <= '0;
      ver_r     <= '0;
      type_r    <= '0;
      id_r      <= '0;
      reqver_r  <= '0;
      crc_r     <= fprx_pkg::CRC_INIT;
      trailer_r <= '0;
      kidx_r    <= '0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      len_r     <= len_nxt;
      ver_r     <= ver_nxt;
      type_r    <= type_nxt;
      id_r      <= id_nxt;
      reqver_r  <= reqver_nxt;
      crc_r     <= crc_nxt;
      trailer_r <= trailer_nxt;
      kidx_r    <= kidx_nxt;
    end
  end

  always_comb begin
    res.plain_byte       = plain;
    res.payload_flag     = payload;
    res.frame_end        = fend;
    res.status           = status;
    res.protocol_version = ver_nxt;
    res.message_type     = type_nxt;
    res.request_id       = id_nxt;
    res.request_version  = reqver_nxt;
    res.frame_length     = len_nxt;
  end

endmodule

`default_nettype wire

// ----- sv/framed_packet_receiver_xor_crc.sv -----
// the result of each accepted word is registered in the output register
// throughput: one word per cycle while in_stall is low; header parse, key xor and byte-wide crc update share one stage
// the single output register is refilled in the cycle it is taken, so a stall only holds input
// reset: synchronous active-low rst_n; parser returns to stx hunt, crc to all ones,
// configuration registers to their defaults, output register empty
`default_nettype none

module framed_packet_receiver_xor_crc #(
  parameter int MAX_KEY_BYTES = fprx_pkg::MAX_KEY_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [7:0]                    in_rx_byte,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [7:0]                         out_plain_byte,
  output logic                               out_payload_flag,
  output logic                               out_frame_end,
  output logic [2:0]                         out_status,
  output logic [7:0]                         out_protocol_version,
  output logic [15:0]                        out_message_type,
  output logic [7:0]                         out_request_id,
  output logic [7:0]                         out_request_version,
  output logic [31:0]                        out_frame_length,
  input  wire logic                          cfg_we,
  input  wire logic [fprx_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]                   cfg_data
);

  fprx_pkg::cfg_t    cfg_r;
  fprx_pkg::result_t res;
  fprx_pkg::result_t res_r;
  logic              out_valid_r;
  logic              step;

  assign in_stall = out_valid_r && out_stall;
  assign step     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.xor_key     <= fprx_pkg::RST_XOR_KEY;
      cfg_r.key_length  <= fprx_pkg::RST_KEY_LENGTH;
      cfg_r.max_frame   <= fprx_pkg::RST_MAX_FRAME;
      cfg_r.min_version <= fprx_pkg::RST_MIN_VERSION;
      cfg_r.max_version <= fprx_pkg::RST_MAX_VERSION;
    end else if (cfg_we) begin
      case (cfg_index)
        fprx_pkg::CFG_XOR_KEY:     cfg_r.xor_key     <= cfg_data;
        fprx_pkg::CFG_KEY_LENGTH:  cfg_r.key_length  <= cfg_data[3:0];
        fprx_pkg::CFG_MAX_FRAME:   cfg_r.max_frame   <= cfg_data[31:0];
        fprx_pkg::CFG_MIN_VERSION: cfg_r.min_version <= cfg_data[7:0];
        fprx_pkg::CFG_MAX_VERSION: cfg_r.max_version <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  fprx_parser #(
    .MAX_KEY_BYTES(MAX_KEY_BYTES)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (in_rx_byte),
    .cfg     (cfg_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_plain_byte       = res_r.plain_byte;
  assign out_payload_flag     = res_r.payload_flag;
  assign out_frame_end        = res_r.frame_end;
  assign out_status           = res_r.status;
  assign out_protocol_version = res_r.protocol_version;
  assign out_message_type     = res_r.message_type;
  assign out_request_id       = res_r.request_id;
  assign out_request_version  = res_r.request_version;
  assign out_frame_length     = res_r.frame_length;

endmodule

`default_nettype wire

// ----- sv/fprx_checker.sv -----
`default_nettype none

module fprx_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [7:0]  out_plain_byte,
  input wire logic        out_payload_flag,
  input wire logic        out_frame_end,
  input wire logic [2:0]  out_status,
  input wire logic [31:0] out_frame_length
);

  // a held result word keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_plain_byte) && $stable(out_status))
    else $error("result word changed while stalled");

  // payload bytes are never the last byte of a frame and carry busy status
  a_payload_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload_flag |-> !out_frame_end && out_status == fprx_pkg::ST_BUSY)
    else $error("payload byte carries an end or status");

  // frame end marks exactly the words with a final verdict
  a_end_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_frame_end == (out_status != fprx_pkg::ST_BUSY &&
                                    out_status != fprx_pkg::ST_DISCARD))
    else $error("frame end does not match status");

  // a good frame had a length that passed the lower bound
  a_good_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == fprx_pkg::ST_GOOD |-> out_frame_length >= fprx_pkg::MIN_FRAME_LEN)
    else $error("good frame with short length");

endmodule

bind framed_packet_receiver_xor_crc fprx_checker u_fprx_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_plain_byte   (out_plain_byte),
  .out_payload_flag (out_payload_flag),
  .out_frame_end    (out_frame_end),
  .out_status       (out_status),
  .out_frame_length (out_frame_length)
);

`default_nettype wire
